### rtl/fsc_pkg.sv
package fsc_pkg;

   // Field widths of the item streams.
   localparam int COORD_W    = 32;
   localparam int IDX_W      = 5;
   localparam int COV_W      = 17;
   localparam int STATUS_W   = 2;
   localparam int SLOTS      = 24;
   localparam int PLANE_W    = 3;
   localparam int NEAR_PLANE = 4;
   localparam int LAST_PLANE = 5;

   // Request tdata layout, lowest bit first.
   localparam int IDX_LSB    = 0;
   localparam int COEF_LSB   = IDX_LSB + IDX_W;
   localparam int XMIN_LSB   = COEF_LSB + COORD_W;
   localparam int XMAX_LSB   = XMIN_LSB + COORD_W;
   localparam int YMIN_LSB   = XMAX_LSB + COORD_W;
   localparam int YMAX_LSB   = YMIN_LSB + COORD_W;
   localparam int ZMIN_LSB   = YMAX_LSB + COORD_W;
   localparam int ZMAX_LSB   = ZMIN_LSB + COORD_W;
   localparam int REQ_BITS   = ZMAX_LSB + COORD_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;

   // Response tdata layout, lowest bit first.
   localparam int COV_LSB    = 0;
   localparam int DIST_LSB   = COV_LSB + COV_W;
   localparam int RSP_BITS   = DIST_LSB + COORD_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // Internal datapath widths.
   localparam int SUM_W  = COORD_W + 1;        // bound sums and box edges
   localparam int T_W    = 2 * COORD_W + 4;    // twice a plane distance
   localparam int P_W    = T_W + 2;            // extents and multiplier operand
   localparam int W_W    = 2 * P_W + 4;        // shared adder and accumulator
   localparam int ROOT_W = COORD_W + 2;        // diameter
   localparam int REM_W  = ROOT_W + 4;         // square root remainder
   localparam int RAD_W  = 2 * ROOT_W;         // square root radicand
   localparam int CNT_W  = 7;
   localparam int Q_W    = 16;
   localparam int FRAC_SHIFT = 16;
   localparam int DD_SHIFT   = 17;

   localparam logic [COV_W-1:0] COV_ONE = COV_W'(1) << Q_W;
   localparam logic signed [T_W-1:0] NEAR_HI = T_W'(1) << 48;
   localparam logic signed [T_W-1:0] NEAR_LO = -NEAR_HI;
   localparam logic [COORD_W-1:0] DIST_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] DIST_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   localparam logic CMD_LOAD = 1'b0;

   typedef enum logic [STATUS_W-1:0] {
      ST_VISIBLE   = 2'd0,
      ST_CULLED    = 2'd1,
      ST_INVALID   = 2'd2,
      ST_ZERO_AREA = 2'd3
   } status_type;

endpackage

### rtl/frustum_screen_coverage.sv
// Frustum culling and screen coverage of a box's bounding sphere. A request item with
// tuser 0 loads one of 24 plane coefficients (slot = plane*4 + term, slots above 23 are
// ignored) and returns no result. A request item with tuser 1 evaluates an
// axis-aligned box and returns exactly one response item: the box is culled if its
// bounding sphere lies wholly behind any of the six planes, otherwise the response gives
// the Q1.16 fraction of the view slice the sphere covers and the center's Q16.16 distance
// from the near plane (plane 4). Status in tuser tells visible, culled, invalid bounds or
// zero area apart. The wide arithmetic runs through one 144-bit adder/subtractor under a
// small sequencer: multiplies go one multiplier bit per cycle, the diameter square root
// one root bit per cycle and the final ratio one quotient bit per cycle. A visible box
// spends most of its time in the eighteen 33-step multiplies of the six plane dot
// products and the two 70-step extent products; a culled box ends at its culling plane
// and invalid bounds end in S_CHECK. The block takes no request while a box is in work,
// but it takes the next request while a finished response still waits in the output
// register.
module frustum_screen_coverage (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // coef_index, coef_value, x_min, x_max, y_min, y_max, z_min, z_max, zero fill
   input  logic [fsc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // command
   input  logic [0:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // coverage, near_distance, zero fill
   output logic [fsc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status
   output logic [fsc_pkg::STATUS_W-1:0]     rsp_tuser
);
   import fsc_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_CHECK, S_SQ_LOAD, S_SQ_NEXT, S_SQRT, S_PL_INIT, S_PL_LOAD, S_PL_NEXT,
      S_PL_TEST, S_MUL, S_FW, S_FH, S_ZCHK, S_PART, S_PROD, S_PROD_A, S_PROD_B,
      S_RATIO, S_NEG_N, S_NEG_D, S_CMP, S_DIV, S_DONE
   } state_type;

   state_type state_ff;
   state_type ret_ff;

   logic signed [COORD_W-1:0] coef_ff [SLOTS];
   logic signed [COORD_W-1:0] lo_ff [3];
   logic signed [COORD_W-1:0] hi_ff [3];
   logic signed [T_W-1:0]     t_ff [4];

   logic [1:0]         axis_ff;
   logic [PLANE_W-1:0] plane_ff;
   logic [2:0]         step_ff;
   logic [CNT_W-1:0]   cnt_ff;

   // Shared multiply datapath: accumulator, shifting multiplicand, shifting multiplier.
   logic [W_W-1:0] acc_ff;
   logic [W_W-1:0] mc_ff;
   logic [P_W-1:0] mp_ff;
   logic [W_W-1:0] num_ff;
   logic [W_W-1:0] den_ff;

   logic [RAD_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;

   logic signed [P_W-1:0] fw_ff;
   logic signed [P_W-1:0] fh_ff;
   logic signed [P_W-1:0] pw_ff;
   logic signed [P_W-1:0] ph_ff;
   logic signed [P_W-1:0] tmp_ff;
   logic [COORD_W-1:0]    dist_ff;
   logic [Q_W-1:0]        q_ff;

   logic               rsp_valid_ff;
   logic [COV_W-1:0]   res_cov_ff;
   logic [COORD_W-1:0] res_dist_ff;
   status_type         res_status_ff;
   logic [COV_W-1:0]   rsp_cov_ff;
   logic [COORD_W-1:0] rsp_dist_ff;
   status_type         rsp_status_ff;

   logic                    req_fire;
   logic signed [SUM_W-1:0] edge_len;
   logic signed [SUM_W-1:0] sum2;
   logic signed [COORD_W-1:0] coef_sel;
   logic [IDX_W-1:0]        coef_addr;
   logic [IDX_W-1:0]        load_idx;
   logic                    bad_bounds;
   logic [REM_W-1:0]        rem_sh;
   logic [REM_W-1:0]        trial;
   logic [W_W-1:0]          num_sh;
   logic [ROOT_W+FRAC_SHIFT-1:0] r2;
   logic signed [P_W-1:0]   part_src;
   logic signed [P_W-1:0]   sb_pos;
   logic signed [T_W-1:0]   acc_t;
   logic [COORD_W-1:0]      near_v;
   logic [Q_W-1:0]          q_nx;
   logic [W_W-1:0]          alu_a;
   logic [W_W-1:0]          alu_b;
   logic                    alu_sub;
   logic [W_W-1:0]          alu_res;
   logic                    alu_neg;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign load_idx   = req_tdata[IDX_LSB +: IDX_W];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_dist_ff, rsp_cov_ff});
   assign rsp_tuser  = rsp_status_ff;

   // Per-axis operands: box edge (never negative once bounds are valid) and twice the
   // center coordinate.
   assign edge_len = {hi_ff[axis_ff][COORD_W-1], hi_ff[axis_ff]}
                   - {lo_ff[axis_ff][COORD_W-1], lo_ff[axis_ff]};
   assign sum2     = {hi_ff[axis_ff][COORD_W-1], hi_ff[axis_ff]}
                   + {lo_ff[axis_ff][COORD_W-1], lo_ff[axis_ff]};

   // One read port on the coefficient file; axis 3 selects the constant term.
   assign coef_addr = {plane_ff, axis_ff};
   assign coef_sel  = coef_ff[coef_addr];

   assign bad_bounds = (lo_ff[0] > hi_ff[0]) || (lo_ff[1] > hi_ff[1])
                    || (lo_ff[2] > hi_ff[2]);

   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial  = REM_W'({root_ff, 2'b01});
   assign num_sh = {num_ff[W_W-2:0], 1'b0};
   assign r2     = {root_ff, {FRAC_SHIFT{1'b0}}};
   assign q_nx   = {q_ff[Q_W-2:0], ~alu_neg};

   // The part extent subtracts only the positive side overhangs.
   assign sb_pos = tmp_ff[P_W-1] ? '0 : tmp_ff;

   always_comb begin
      unique case (step_ff[2:1])
         2'd0: part_src = fw_ff;
         2'd1: part_src = pw_ff;
         2'd2: part_src = fh_ff;
         default: part_src = ph_ff;
      endcase
   end

   // Near distance is floor(t/2) at Q16.16, saturated to the signed 32-bit range.
   assign acc_t = acc_ff[T_W-1:0];
   always_comb begin
      priority if (acc_t >= NEAR_HI) begin
         near_v = DIST_MAX;
      end else if (acc_t < NEAR_LO) begin
         near_v = DIST_MIN;
      end else begin
         near_v = acc_t[DD_SHIFT +: COORD_W];
      end
   end

   // Operand selection for the shared adder/subtractor.
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      unique case (state_ff)
         S_MUL: begin
            alu_a   = acc_ff;
            alu_b   = mc_ff;
            alu_sub = (cnt_ff == CNT_W'(1));   // sign bit of the multiplier weighs negative
         end
         S_SQRT: begin
            alu_a   = W_W'(rem_sh);
            alu_b   = W_W'(trial);
            alu_sub = 1'b1;
         end
         S_PL_TEST: begin
            alu_a = acc_ff;
            alu_b = W_W'(r2);
         end
         S_FW: begin
            alu_a = W_W'(t_ff[0]);
            alu_b = W_W'(t_ff[1]);
         end
         S_FH: begin
            alu_a = W_W'(t_ff[2]);
            alu_b = W_W'(t_ff[3]);
         end
         S_PART: begin
            alu_sub = 1'b1;
            if (!step_ff[0]) begin
               alu_a = W_W'(t_ff[step_ff[2:1]]);
               alu_b = W_W'(r2);
            end else begin
               alu_a = W_W'(part_src);
               alu_b = W_W'(sb_pos);
            end
         end
         S_NEG_N: begin
            alu_b   = num_ff;
            alu_sub = 1'b1;
         end
         S_NEG_D: begin
            alu_b   = den_ff;
            alu_sub = 1'b1;
         end
         S_CMP: begin
            alu_a   = num_ff;
            alu_b   = den_ff;
            alu_sub = 1'b1;
         end
         S_DIV: begin
            alu_a   = num_sh;
            alu_b   = den_ff;
            alu_sub = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + W_W'(alu_sub);
   assign alu_neg = alu_res[W_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            coef_ff[i] <= '0;
         end
      end else begin
         // In S_DONE the output register is refilled below instead.
         if (rsp_valid_ff && rsp_tready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  if (req_tuser[0] == CMD_LOAD) begin
                     if (load_idx < IDX_W'(SLOTS)) begin
                        coef_ff[load_idx] <= req_tdata[COEF_LSB +: COORD_W];
                     end
                  end else begin
                     lo_ff[0] <= req_tdata[XMIN_LSB +: COORD_W];
                     hi_ff[0] <= req_tdata[XMAX_LSB +: COORD_W];
                     lo_ff[1] <= req_tdata[YMIN_LSB +: COORD_W];
                     hi_ff[1] <= req_tdata[YMAX_LSB +: COORD_W];
                     lo_ff[2] <= req_tdata[ZMIN_LSB +: COORD_W];
                     hi_ff[2] <= req_tdata[ZMAX_LSB +: COORD_W];
                     state_ff <= S_CHECK;
                  end
               end
            end
            S_CHECK: begin
               if (bad_bounds) begin
                  res_cov_ff    <= '0;
                  res_dist_ff   <= '0;
                  res_status_ff <= ST_INVALID;
                  state_ff      <= S_DONE;
               end else begin
                  acc_ff   <= '0;
                  axis_ff  <= 2'd0;
                  state_ff <= S_SQ_LOAD;
               end
            end
            S_SQ_LOAD: begin
               mc_ff    <= W_W'(edge_len);
               mp_ff    <= P_W'(edge_len);
               cnt_ff   <= CNT_W'(SUM_W);
               ret_ff   <= S_SQ_NEXT;
               state_ff <= S_MUL;
            end
            S_SQ_NEXT: begin
               if (axis_ff == 2'd2) begin
                  rad_ff   <= acc_ff[RAD_W-1:0];
                  rem_ff   <= '0;
                  root_ff  <= '0;
                  cnt_ff   <= CNT_W'(ROOT_W);
                  state_ff <= S_SQRT;
               end else begin
                  axis_ff  <= axis_ff + 2'd1;
                  state_ff <= S_SQ_LOAD;
               end
            end
            S_SQRT: begin
               if (!alu_neg) begin
                  rem_ff  <= alu_res[REM_W-1:0];
                  root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
               end else begin
                  rem_ff  <= rem_sh;
                  root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
               end
               rad_ff <= rad_ff << 2;
               cnt_ff <= cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  plane_ff <= '0;
                  axis_ff  <= 2'd3;
                  state_ff <= S_PL_INIT;
               end
            end
            S_PL_INIT: begin
               acc_ff   <= W_W'(coef_sel) << DD_SHIFT;
               axis_ff  <= 2'd0;
               state_ff <= S_PL_LOAD;
            end
            S_PL_LOAD: begin
               mc_ff    <= W_W'(coef_sel);
               mp_ff    <= P_W'(sum2);
               cnt_ff   <= CNT_W'(SUM_W);
               ret_ff   <= S_PL_NEXT;
               state_ff <= S_MUL;
            end
            S_PL_NEXT: begin
               if (axis_ff == 2'd2) begin
                  state_ff <= S_PL_TEST;
               end else begin
                  axis_ff  <= axis_ff + 2'd1;
                  state_ff <= S_PL_LOAD;
               end
            end
            S_PL_TEST: begin
               if (alu_neg) begin
                  // Center lies more than the radius behind this plane.
                  res_cov_ff    <= '0;
                  res_dist_ff   <= (plane_ff == PLANE_W'(LAST_PLANE)) ? dist_ff : '0;
                  res_status_ff <= ST_CULLED;
                  state_ff      <= S_DONE;
               end else begin
                  if (plane_ff < PLANE_W'(NEAR_PLANE)) begin
                     t_ff[plane_ff[1:0]] <= acc_t;
                  end
                  if (plane_ff == PLANE_W'(NEAR_PLANE)) begin
                     dist_ff <= near_v;
                  end
                  if (plane_ff == PLANE_W'(LAST_PLANE)) begin
                     state_ff <= S_FW;
                  end else begin
                     plane_ff <= plane_ff + PLANE_W'(1);
                     axis_ff  <= 2'd3;
                     state_ff <= S_PL_INIT;
                  end
               end
            end
            S_MUL: begin
               if (mp_ff[0]) begin
                  acc_ff <= alu_res;
               end
               mc_ff  <= mc_ff << 1;
               mp_ff  <= mp_ff >> 1;
               cnt_ff <= cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  state_ff <= ret_ff;
               end
            end
            S_FW: begin
               fw_ff    <= alu_res[P_W-1:0];
               state_ff <= S_FH;
            end
            S_FH: begin
               fh_ff    <= alu_res[P_W-1:0];
               state_ff <= S_ZCHK;
            end
            S_ZCHK: begin
               if (fw_ff == '0 || fh_ff == '0) begin
                  res_cov_ff    <= '0;
                  res_dist_ff   <= dist_ff;
                  res_status_ff <= ST_ZERO_AREA;
                  state_ff      <= S_DONE;
               end else begin
                  step_ff  <= '0;
                  state_ff <= S_PART;
               end
            end
            S_PART: begin
               // Even steps form a side overhang, odd steps take it off an extent.
               if (!step_ff[0]) begin
                  tmp_ff <= alu_res[P_W-1:0];
               end else if (!step_ff[2]) begin
                  pw_ff <= alu_res[P_W-1:0];
               end else begin
                  ph_ff <= alu_res[P_W-1:0];
               end
               step_ff <= step_ff + 3'd1;
               if (step_ff == 3'd7) begin
                  state_ff <= S_PROD;
               end
            end
            S_PROD: begin
               acc_ff   <= '0;
               mc_ff    <= W_W'(pw_ff);
               mp_ff    <= ph_ff;
               cnt_ff   <= CNT_W'(P_W);
               ret_ff   <= S_PROD_A;
               state_ff <= S_MUL;
            end
            S_PROD_A: begin
               num_ff   <= acc_ff;
               acc_ff   <= '0;
               mc_ff    <= W_W'(fw_ff);
               mp_ff    <= fh_ff;
               cnt_ff   <= CNT_W'(P_W);
               ret_ff   <= S_PROD_B;
               state_ff <= S_MUL;
            end
            S_PROD_B: begin
               den_ff   <= acc_ff;
               state_ff <= S_RATIO;
            end
            S_RATIO: begin
               if (num_ff == '0 || num_ff[W_W-1] != den_ff[W_W-1]) begin
                  res_cov_ff    <= '0;
                  res_dist_ff   <= dist_ff;
                  res_status_ff <= ST_VISIBLE;
                  state_ff      <= S_DONE;
               end else begin
                  state_ff <= S_NEG_N;
               end
            end
            S_NEG_N: begin
               if (num_ff[W_W-1]) begin
                  num_ff <= alu_res;
               end
               state_ff <= S_NEG_D;
            end
            S_NEG_D: begin
               if (den_ff[W_W-1]) begin
                  den_ff <= alu_res;
               end
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (!alu_neg) begin
                  res_cov_ff    <= COV_ONE;
                  res_dist_ff   <= dist_ff;
                  res_status_ff <= ST_VISIBLE;
                  state_ff      <= S_DONE;
               end else begin
                  q_ff     <= '0;
                  cnt_ff   <= CNT_W'(Q_W);
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               num_ff <= alu_neg ? num_sh : alu_res;
               q_ff   <= q_nx;
               cnt_ff <= cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  res_cov_ff    <= COV_W'(q_nx);
                  res_dist_ff   <= dist_ff;
                  res_status_ff <= ST_VISIBLE;
                  state_ff      <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_cov_ff    <= res_cov_ff;
                  rsp_dist_ff   <= res_dist_ff;
                  rsp_status_ff <= res_status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Coverage never exceeds one.
   a_cov_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_cov_ff <= COV_ONE))
      else $error("coverage above one");

   // Only a visible box carries a nonzero coverage.
   a_cov_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_VISIBLE) |-> (rsp_cov_ff == '0))
      else $error("nonzero coverage on a box that is not visible");

   // Invalid bounds report a zero distance.
   a_invalid_dist: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_INVALID) |-> (rsp_dist_ff == '0))
      else $error("distance on invalid bounds");

   // A coefficient load finishes in its own cycle.
   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser[0] == CMD_LOAD) |=> req_tready)
      else $error("load item held the block busy");

endmodule
